### design/nntt_pkg.sv
package nntt_pkg;

  localparam int COORD_W   = 16;
  localparam int RANGE_W   = 16;
  localparam int GATE_W    = 34;
  localparam int CNO_W     = 8;
  localparam int LIFE_W    = 8;
  localparam int CFG_W     = 34;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_SQ = 2'd0,
    CFG_LIFE    = 2'd1,
    CFG_AVG     = 2'd2,
    CFG_LIMIT   = 2'd3
  } cfg_idx_e;

  // [2] x, [1] y, [0] z
  typedef logic [2:0][COORD_W-1:0] coord3_t;

  typedef enum logic [1:0] {
    STAT_NEW,
    STAT_NEW2,
    STAT_UPD,
    STAT_COAST
  } stat_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD,
    CELL_DROP
  } cell_op_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SCAN,
    PH_APPLY,
    PH_SUM,
    PH_DIV,
    PH_AGE,
    PH_COMPACT,
    PH_REPORT
  } phase_e;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [GATE_W-1:0] od;
  } dist_res_t;

endpackage

### design/nntt_cell.sv
module nntt_cell #(
  parameter int W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nntt_pkg::cell_op_e op_i,
  input  logic               nxt_vld_i,
  input  logic [W-1:0]       nxt_i,
  input  logic [W-1:0]       ext_i,
  output logic               vld_o,
  output logic [W-1:0]       data_o
);
  import nntt_pkg::*;

  logic         vld_q;
  logic [W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      case (op_i)
        CELL_SHIFT: vld_q <= nxt_vld_i;
        CELL_LOAD:  vld_q <= 1'b1;
        CELL_DROP:  vld_q <= 1'b0;
        default:    vld_q <= vld_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_SHIFT: data_q <= nxt_i;
      CELL_LOAD:  data_q <= ext_i;
      default:    data_q <= data_q;
    endcase
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

### design/nntt_dist.sv
module nntt_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          live_i,
  input  logic [nntt_pkg::CNO_W-1:0]    ent_cno_i,
  input  nntt_pkg::coord3_t             ent_crane_i,
  input  nntt_pkg::coord3_t             ent_obj_i,
  input  logic [nntt_pkg::CNO_W-1:0]    m_cno_i,
  input  nntt_pkg::coord3_t             m_crane_i,
  input  nntt_pkg::coord3_t             m_obj_i,
  input  logic [nntt_pkg::GATE_W-1:0]   gate_i,
  output nntt_pkg::dist_res_t           res_o
);
  import nntt_pkg::*;

  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  logic                     v1_q, ok1_q, v2_q, ok2_q;
  logic signed [DW-1:0]     dc_q [3];
  logic signed [DW-1:0]     do_q [3];
  logic        [GATE_W-1:0] sc_q [3];
  logic        [GATE_W-1:0] so_q [3];
  logic        [GATE_W-1:0] csum, osum;
  dist_res_t                res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      res_q <= '0;
    end else begin
      v1_q      <= en_i;
      v2_q      <= v1_q;
      res_q.vld <= v2_q;
      res_q.hit <= ok2_q && (csum <= gate_i) && (osum < gate_i);
      res_q.od  <= osum;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q <= live_i && (ent_cno_i == m_cno_i);
    ok2_q <= ok1_q;
    for (int k = 0; k < 3; k++) begin
      dc_q[k] <= DW'(signed'(ent_crane_i[k])) - DW'(signed'(m_crane_i[k]));
      do_q[k] <= DW'(signed'(ent_obj_i[k])) - DW'(signed'(m_obj_i[k]));
      sc_q[k] <= GATE_W'(unsigned'(PW'(dc_q[k]) * PW'(dc_q[k])));
      so_q[k] <= GATE_W'(unsigned'(PW'(do_q[k]) * PW'(do_q[k])));
    end
  end

  assign csum  = sc_q[0] + sc_q[1] + sc_q[2];
  assign osum  = so_q[0] + so_q[1] + so_q[2];
  assign res_o = res_q;

endmodule

### design/nntt_div.sv
module nntt_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  import nntt_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial;
  logic             take;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_q <= {quo_q[NUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### design/nearest_neighbour_track_table_core.sv
// Gated nearest-neighbour track table.
// Input channel (in_valid_i / in_stall_o): func_i = 0 is a measurement, func_i = 1
// closes a frame. in_stall_o is high while an item is in work, one item at a time.
// Output channel (out_valid_o / out_stall_i): one transaction per reported track,
// only after a frame end, in creation order; last_of_frame_o marks the final one.
// Tracks live in a row of MAX_TRACKS cells, rotating one slot per cycle while shifted,
// past a head where the distance pipeline, the update logic and the reporter sit.
// Measurement: a gating scan over all cells; a dropped measurement ends there.
// Otherwise a rotation pass applies the result, and a matched track also runs the
// averaging divider (one quotient bit per cycle) before its entry is loaded back.
// Frame end: an aging pass and a compaction pass, then, if any track is reported, a
// report pass, which a stalled output can hold.
// A stalled result sits in the output register and holds the report rotation;
// the next item is taken as soon as the report pass ends.
// Reset empties the table and loads the register defaults. Configuration writes
// are taken at any cycle with cfg_we_i high.
module nearest_neighbour_track_table_core #(
  parameter int MAX_TRACKS = 32,
  parameter int MAX_AVG    = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [nntt_pkg::CNO_W-1:0]         crane_no_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] crane_x_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] crane_y_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] crane_z_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] object_x_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] object_y_i,
  input  logic signed [nntt_pkg::COORD_W-1:0] object_z_i,
  input  logic [nntt_pkg::RANGE_W-1:0]       range_mm_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [nntt_pkg::CNO_W-1:0]         out_crane_no_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_crane_x_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_crane_y_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_crane_z_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_object_x_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_object_y_o,
  output logic signed [nntt_pkg::COORD_W-1:0] out_object_z_o,
  output logic [nntt_pkg::RANGE_W-1:0]       smoothed_mm_o,
  output logic                               coasting_o,
  output logic                               last_of_frame_o,
  input  logic                               cfg_we_i,
  input  logic [nntt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nntt_pkg::CFG_W-1:0]         cfg_data_i
);
  import nntt_pkg::*;

  localparam int CW = $clog2(MAX_AVG + 1);
  localparam int NW = $clog2(MAX_TRACKS + 1);
  localparam int KW = $clog2(2 * MAX_TRACKS + 1);
  localparam int LW = NW + 6;
  localparam int SW = RANGE_W + CW;
  localparam int AW = CW + 4;

  typedef logic [MAX_AVG-1:0][RANGE_W-1:0] hist_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic               touched;
    stat_e              status;
    logic [LIFE_W-1:0]  life;
    logic [CNO_W-1:0]   cno;
    coord3_t            crane;
    coord3_t            obj;
    logic [RANGE_W-1:0] smoothed;
    cnt_t               hcnt;
    hist_t              hist;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic hist_t hist_drop(hist_t h);
    hist_t r;
    r = h;
    for (int j = 0; j < MAX_AVG - 1; j++) r[j] = h[j+1];
    return r;
  endfunction

  function automatic entry_t hist_push(entry_t e, logic [RANGE_W-1:0] v, cnt_t eff);
    entry_t r;
    r = e;
    if (r.hcnt >= cnt_t'(MAX_AVG)) begin
      r.hist = hist_drop(r.hist);
      r.hcnt = r.hcnt - cnt_t'(1);
    end
    for (int j = 0; j < MAX_AVG; j++) begin
      if (cnt_t'(j) == r.hcnt) r.hist[j] = v;
    end
    r.hcnt = r.hcnt + cnt_t'(1);
    if (r.hcnt > eff) begin
      r.hist = hist_drop(r.hist);
      r.hcnt = r.hcnt - cnt_t'(1);
    end
    return r;
  endfunction

  function automatic logic [RANGE_W-1:0] hist_last(entry_t e);
    logic [RANGE_W-1:0] v;
    v = '0;
    for (int j = 0; j < MAX_AVG; j++) begin
      if (cnt_t'(j + 1) == e.hcnt) v = e.hist[j];
    end
    return v;
  endfunction

  // configuration
  logic [GATE_W-1:0] gate_q;
  logic [LIFE_W-1:0] life_q;
  logic [3:0]        avg_q;
  logic [5:0]        lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= GATE_W'(1000000);
      life_q <= LIFE_W'(5);
      avg_q  <= 4'd3;
      lim_q  <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GATE_SQ: gate_q <= cfg_data_i[GATE_W-1:0];
        CFG_LIFE:    life_q <= cfg_data_i[LIFE_W-1:0];
        CFG_AVG:     avg_q  <= cfg_data_i[3:0];
        CFG_LIMIT:   lim_q  <= cfg_data_i[5:0];
        default:     ;
      endcase
    end
  end

  logic [AW-1:0] avg_c;
  cnt_t          eff_avg;
  logic [LW-1:0] lim_eff;

  always_comb begin
    avg_c = AW'(avg_q);
    if (avg_c < AW'(1)) avg_c = AW'(1);
    if (avg_c > AW'(MAX_AVG)) avg_c = AW'(MAX_AVG);
    eff_avg = CW'(avg_c);
    lim_eff = (LW'(lim_q) > LW'(MAX_TRACKS)) ? LW'(MAX_TRACKS) : LW'(lim_q);
  end

  // captured measurement
  logic [CNO_W-1:0]   m_cno_q;
  coord3_t            m_crane_q, m_obj_q;
  logic [RANGE_W-1:0] m_rng_q;

  // cell row
  logic [MAX_TRACKS-1:0] cell_vld;
  logic [MAX_TRACKS-1:0] nxt_vld;
  entry_t                cell_data [MAX_TRACKS];
  entry_t                nxt_data  [MAX_TRACKS];
  cell_op_e              cell_op   [MAX_TRACKS];
  logic                  ring_shift, ring_compact, head_load;
  logic                  tail_vld;
  entry_t                tail_data, head_ext, head;

  assign head = cell_data[0];

  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
    logic     prev_vld;
    cell_op_e comp_op;
    entry_t   ext_data;

    if (i == MAX_TRACKS - 1) begin : g_tail
      assign nxt_vld[i]  = tail_vld;
      assign nxt_data[i] = tail_data;
    end else begin : g_mid
      assign nxt_vld[i]  = cell_vld[i+1];
      assign nxt_data[i] = cell_data[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_vld = 1'b1;
      assign ext_data = head_ext;
    end else begin : g_body
      assign prev_vld = cell_vld[i-1];
      assign ext_data = '0;
    end

    // a hole moves back one cell per cycle, entries keep their order
    assign comp_op = (!cell_vld[i] && nxt_vld[i]) ? CELL_SHIFT :
                     (cell_vld[i] && !prev_vld)   ? CELL_DROP  : CELL_HOLD;

    assign cell_op[i] = ring_shift   ? CELL_SHIFT :
                        ring_compact ? comp_op    :
                        (head_load && i == 0) ? CELL_LOAD : CELL_HOLD;

    nntt_cell #(
      .W(EW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (cell_op[i]),
      .nxt_vld_i(nxt_vld[i]),
      .nxt_i    (nxt_data[i]),
      .ext_i    (ext_data),
      .vld_o    (cell_vld[i]),
      .data_o   (cell_data[i])
    );
  end

  // distance pipeline at the head
  logic      dist_en;
  dist_res_t dres;

  nntt_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (dist_en),
    .live_i     (cell_vld[0]),
    .ent_cno_i  (head.cno),
    .ent_crane_i(head.crane),
    .ent_obj_i  (head.obj),
    .m_cno_i    (m_cno_q),
    .m_crane_i  (m_crane_q),
    .m_obj_i    (m_obj_q),
    .gate_i     (gate_q),
    .res_o      (dres)
  );

  // averaging divider
  entry_t        upd_q, upd_d;
  logic          div_start, div_done;
  logic [SW-1:0] div_quo, hsum;

  always_comb begin
    hsum = '0;
    for (int j = 0; j < MAX_AVG; j++) begin
      if (cnt_t'(j) < upd_q.hcnt) hsum = hsum + SW'(upd_q.hist[j]);
    end
  end

  nntt_div #(
    .NUM_W(SW),
    .DEN_W(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (hsum),
    .den_i  (upd_q.hcnt),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // entry builders
  entry_t upd_ent, new_ent, age_ent, fin_ent;
  logic   age_keep;

  always_comb begin
    upd_ent       = head;
    upd_ent.cno   = m_cno_q;
    upd_ent.crane = m_crane_q;
    upd_ent.obj   = m_obj_q;
    if (!head.touched) begin
      upd_ent.touched = 1'b1;
      upd_ent.life    = life_q;
      upd_ent.status  = (head.status == STAT_NEW) ? STAT_NEW2 : STAT_UPD;
      upd_ent         = hist_push(upd_ent, m_rng_q, eff_avg);
    end else if (head.hcnt == '0) begin
      upd_ent = hist_push(upd_ent, m_rng_q, eff_avg);
    end else begin
      // repeat match in the frame keeps the smaller newest value
      for (int j = 0; j < MAX_AVG; j++) begin
        if (cnt_t'(j + 1) == head.hcnt && m_rng_q < head.hist[j]) upd_ent.hist[j] = m_rng_q;
      end
    end

    new_ent          = '0;
    new_ent.touched  = 1'b1;
    new_ent.status   = STAT_NEW;
    new_ent.life     = life_q;
    new_ent.cno      = m_cno_q;
    new_ent.crane    = m_crane_q;
    new_ent.obj      = m_obj_q;
    new_ent.smoothed = m_rng_q;
    new_ent          = hist_push(new_ent, m_rng_q, eff_avg);

    fin_ent          = upd_q;
    fin_ent.smoothed = RANGE_W'(div_quo);

    age_ent         = head;
    age_ent.touched = 1'b0;
    age_keep        = cell_vld[0];
    if (cell_vld[0] && !head.touched) begin
      age_ent.life = head.life - LIFE_W'(1);
      if (age_ent.life != '0 && head.status != STAT_NEW) begin
        age_ent.status = STAT_COAST;
        age_ent        = hist_push(age_ent, hist_last(head), eff_avg);
      end else begin
        age_keep = 1'b0;
      end
    end
  end

  // sequencer
  phase_e            ph_q, ph_d;
  logic [KW-1:0]     k_q, k_d;
  logic [NW-1:0]     ridx_q, ridx_d, hit_q, hit_d, count_q, count_d;
  logic [NW-1:0]     qual_q, qual_d, rem_q, rem_d, tgt;
  logic              found_q, found_d, done_q, done_d;
  logic [GATE_W-1:0] best_q, best_d;
  logic              can_new, head_qual, age_qual, out_free, out_load;
  logic              out_vld_q;

  assign tgt       = found_q ? hit_q : count_q;
  assign can_new   = LW'(count_q) < lim_eff;
  assign head_qual = cell_vld[0] && (head.status == STAT_UPD || head.status == STAT_COAST);
  assign age_qual  = age_keep && (age_ent.status == STAT_UPD || age_ent.status == STAT_COAST);
  assign out_free  = !out_vld_q || !out_stall_i;

  always_comb begin
    ph_d         = ph_q;
    k_d          = k_q;
    ridx_d       = ridx_q;
    hit_d        = hit_q;
    count_d      = count_q;
    qual_d       = qual_q;
    rem_d        = rem_q;
    found_d      = found_q;
    done_d       = done_q;
    best_d       = best_q;
    upd_d        = upd_q;
    ring_shift   = 1'b0;
    ring_compact = 1'b0;
    head_load    = 1'b0;
    head_ext     = head;
    tail_vld     = cell_vld[0];
    tail_data    = head;
    dist_en      = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    in_stall_o   = 1'b1;
    case (ph_q)
      PH_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          k_d = '0;
          if (func_i) begin
            ph_d    = PH_AGE;
            count_d = '0;
            qual_d  = '0;
          end else begin
            ph_d    = PH_SCAN;
            ridx_d  = '0;
            found_d = 1'b0;
          end
        end
      end
      PH_SCAN: begin
        if (k_q < KW'(MAX_TRACKS)) begin
          ring_shift = 1'b1;
          dist_en    = 1'b1;
          k_d        = k_q + KW'(1);
        end
        // strict compare keeps the older track on a tie
        if (dres.vld) begin
          if (dres.hit && (!found_q || dres.od < best_q)) begin
            found_d = 1'b1;
            best_d  = dres.od;
            hit_d   = ridx_q;
          end
          ridx_d = ridx_q + NW'(1);
        end
        if (ridx_q == NW'(MAX_TRACKS)) begin
          k_d    = '0;
          done_d = 1'b0;
          ph_d   = (found_q || can_new) ? PH_APPLY : PH_IDLE;
        end
      end
      PH_APPLY: begin
        if (k_q == KW'(tgt) && !done_q) begin
          if (found_q) begin
            upd_d = upd_ent;
            ph_d  = PH_SUM;
          end else begin
            head_load = 1'b1;
            head_ext  = new_ent;
            done_d    = 1'b1;
            count_d   = count_q + NW'(1);
          end
        end else if (k_q < KW'(MAX_TRACKS)) begin
          ring_shift = 1'b1;
          k_d        = k_q + KW'(1);
        end else begin
          ph_d = PH_IDLE;
        end
      end
      PH_SUM: begin
        div_start = 1'b1;
        ph_d      = PH_DIV;
      end
      PH_DIV: begin
        if (div_done) begin
          head_load = 1'b1;
          head_ext  = fin_ent;
          done_d    = 1'b1;
          ph_d      = PH_APPLY;
        end
      end
      PH_AGE: begin
        if (k_q < KW'(MAX_TRACKS)) begin
          ring_shift = 1'b1;
          tail_vld   = age_keep;
          tail_data  = age_ent;
          k_d        = k_q + KW'(1);
          if (age_keep) count_d = count_q + NW'(1);
          if (age_qual) qual_d = qual_q + NW'(1);
        end else begin
          k_d  = '0;
          ph_d = PH_COMPACT;
        end
      end
      PH_COMPACT: begin
        tail_vld = 1'b0;
        if (k_q < KW'(2 * MAX_TRACKS)) begin
          ring_compact = 1'b1;
          k_d          = k_q + KW'(1);
        end else begin
          k_d   = '0;
          rem_d = qual_q;
          ph_d  = (qual_q != '0) ? PH_REPORT : PH_IDLE;
        end
      end
      PH_REPORT: begin
        if (k_q < KW'(MAX_TRACKS)) begin
          if (head_qual) begin
            if (out_free) begin
              out_load   = 1'b1;
              rem_d      = rem_q - NW'(1);
              ring_shift = 1'b1;
              k_d        = k_q + KW'(1);
            end
          end else begin
            ring_shift = 1'b1;
            k_d        = k_q + KW'(1);
          end
        end else begin
          ph_d = PH_IDLE;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      k_q     <= '0;
      ridx_q  <= '0;
      count_q <= '0;
      qual_q  <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      k_q     <= k_d;
      ridx_q  <= ridx_d;
      count_q <= count_d;
      qual_q  <= qual_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    best_q <= best_d;
    upd_q  <= upd_d;
    if (ph_q == PH_IDLE && in_valid_i) begin
      m_cno_q   <= crane_no_i;
      m_crane_q <= {crane_x_i, crane_y_i, crane_z_i};
      m_obj_q   <= {object_x_i, object_y_i, object_z_i};
      m_rng_q   <= range_mm_i;
    end
  end

  // output register
  logic [CNO_W-1:0]   o_cno_q;
  coord3_t            o_crane_q, o_obj_q;
  logic [RANGE_W-1:0] o_smooth_q;
  logic               o_coast_q, o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_cno_q    <= head.cno;
      o_crane_q  <= head.crane;
      o_obj_q    <= head.obj;
      o_smooth_q <= head.smoothed;
      o_coast_q  <= (head.status == STAT_COAST);
      o_last_q   <= (rem_q == NW'(1));
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_crane_no_o  = o_cno_q;
  assign out_crane_x_o   = o_crane_q[2];
  assign out_crane_y_o   = o_crane_q[1];
  assign out_crane_z_o   = o_crane_q[0];
  assign out_object_x_o  = o_obj_q[2];
  assign out_object_y_o  = o_obj_q[1];
  assign out_object_z_o  = o_obj_q[0];
  assign smoothed_mm_o   = o_smooth_q;
  assign coasting_o      = o_coast_q;
  assign last_of_frame_o = o_last_q;

endmodule
